FILE: rtl/cel_pkg.sv
// Shared types, constants and the ln(1+f) table for the cross-entropy mean unit.
package cel_pkg;

    // Fixed field widths
    localparam int PROB_W   = 17;
    localparam int MEAN_W   = 20;
    localparam int ROWS_W   = 11;
    localparam int SUM_W    = 30;
    localparam int LOSS_W   = 21;
    localparam int DIVD_W   = SUM_W + 1;
    localparam int LOG2_W   = 5;
    localparam int FRAC_W   = 16;
    localparam int SEG_W    = 4;
    localparam int STEP_W   = 12;
    localparam int TAB_W    = 16;
    localparam int DIFF_W   = 12;
    localparam int PROD_W   = DIFF_W + STEP_W;

    // Block constants
    localparam int MAX_ROWS       = 1024;
    localparam int PROB_FRAC_BITS = 16;
    localparam int COUNT_MAX      = 2047;
    localparam int ROW_CAP_I      = (MAX_ROWS < COUNT_MAX) ? MAX_ROWS : COUNT_MAX;
    localparam logic [ROWS_W-1:0] ROW_CAP    = ROWS_W'(ROW_CAP_I);
    localparam logic [TAB_W-1:0]  LN2_Q16    = 16'd45426;
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX   = {MEAN_W{1'b1}};
    localparam logic [LOG2_W-1:0] FRAC_BITS5 = LOG2_W'(PROB_FRAC_BITS);
    localparam logic [24:0]       INTERP_RND = 25'd2048;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pipe_empty;
        logic div_done;
        logic out_free;
    } t_status;

    // round(65536 * ln(1 + j/16)), j = 0..16
    function automatic logic [TAB_W-1:0] ln1p_tab(input logic [LOG2_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43345;
            5'd16:   v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Index of the highest set bit; zero for a zero word
    function automatic logic [LOG2_W-1:0] lead_one(input logic [PROB_W-1:0] x);
        logic [LOG2_W-1:0] m;
        m = '0;
        for (int b = 0; b < PROB_W; b++) begin
            if (x[b]) begin
                m = LOG2_W'(b);
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/cel_div.sv
// Restoring divider, one quotient bit per cycle, for the batch mean.
module cel_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cel_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [cel_pkg::ROWS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [cel_pkg::DIVD_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(cel_pkg::DIVD_W + 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [cel_pkg::ROWS_W-1:0]   r_rem, n_rem;
    logic [cel_pkg::ROWS_W-1:0]   r_dvs, n_dvs;
    logic [cel_pkg::DIVD_W-1:0]   r_q, n_q;
    logic [cel_pkg::ROWS_W:0]     shifted;
    logic [cel_pkg::ROWS_W:0]     trial;
    logic                         fits;

    assign shifted = {r_rem, r_q[cel_pkg::DIVD_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CNT_W'(cel_pkg::DIVD_W);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_q    = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? cel_pkg::ROWS_W'(trial) : cel_pkg::ROWS_W'(shifted);
            n_q   = {r_q[cel_pkg::DIVD_W-2:0], fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_q   <= n_q;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/cel_dp.sv
// Datapath: log pipeline, loss accumulator, row counter, divider and output register.
module cel_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cel_pkg::t_cmd                 i_cmd,
    output cel_pkg::t_status              o_status,
    input  logic [cel_pkg::PROB_W-1:0]    i_prob,
    input  logic                          i_is_target,
    input  logic                          i_row_end,
    input  logic                          i_batch_end,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [cel_pkg::MEAN_W-1:0]    o_mean_loss,
    output logic [cel_pkg::ROWS_W-1:0]    o_rows_seen
);

    // Row bookkeeping
    logic                          r_found;
    logic [cel_pkg::ROWS_W-1:0]    r_rows;
    logic [cel_pkg::SUM_W-1:0]     r_sum;
    logic                          take;
    logic                          ends_row;

    // Pipeline stages
    logic                          r1_v, r2_v, r3_v, r4_v;
    logic [cel_pkg::PROB_W-1:0]    r1_x;
    logic                          r2_ge1, r3_ge1;
    logic [cel_pkg::LOG2_W-1:0]    r2_e;
    logic [cel_pkg::FRAC_W-1:0]    r2_fr;
    logic [cel_pkg::LOSS_W-1:0]    r3_base;
    logic [cel_pkg::TAB_W-1:0]     r3_tab;
    logic [cel_pkg::PROD_W-1:0]    r3_prod;
    logic [cel_pkg::LOSS_W-1:0]    r4_loss;

    logic [cel_pkg::LOG2_W-1:0]    m1;
    logic [cel_pkg::LOG2_W-1:0]    seg;
    logic [cel_pkg::TAB_W-1:0]     tab_lo, tab_hi;
    logic [cel_pkg::DIFF_W-1:0]    diff;
    logic [cel_pkg::TAB_W:0]       ln1p;
    logic [cel_pkg::DIVD_W-1:0]    sum_next;

    // Divider and output
    logic                          div_done;
    logic [cel_pkg::DIVD_W-1:0]    quot;
    logic [cel_pkg::DIVD_W-1:0]    dividend;
    logic [cel_pkg::ROWS_W-1:0]    r_rows_snap;
    logic                          r_out_valid;
    logic [cel_pkg::MEAN_W-1:0]    r_mean;
    logic [cel_pkg::ROWS_W-1:0]    r_rows_out;

    assign ends_row = i_row_end | i_batch_end;
    assign take     = i_cmd.accept & i_is_target & ~r_found;

    // Stage 2: normalise
    assign m1 = cel_pkg::lead_one(r1_x);

    // Stage 3: table and interpolation product
    assign seg    = {1'b0, r2_fr[cel_pkg::FRAC_W-1 -: cel_pkg::SEG_W]};
    assign tab_lo = cel_pkg::ln1p_tab(seg);
    assign tab_hi = cel_pkg::ln1p_tab(seg + cel_pkg::LOG2_W'(1));
    assign diff   = cel_pkg::DIFF_W'(tab_hi - tab_lo);

    // Stage 4: combine
    assign ln1p = {1'b0, r3_tab}
                + (cel_pkg::TAB_W+1)'((25'(r3_prod) + cel_pkg::INTERP_RND) >> cel_pkg::STEP_W);

    assign sum_next = {1'b0, r_sum} + cel_pkg::DIVD_W'(r4_loss);
    assign dividend = {1'b0, r_sum} + cel_pkg::DIVD_W'(r_rows >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_found     <= 1'b0;
            r_rows      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r1_v <= take;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;

            if (i_cmd.accept) begin
                if (ends_row) begin
                    r_found <= 1'b0;
                end else if (i_is_target) begin
                    r_found <= 1'b1;
                end
                if (ends_row && r_rows < cel_pkg::ROW_CAP) begin
                    r_rows <= r_rows + cel_pkg::ROWS_W'(1);
                end
            end

            if (i_cmd.div_start) begin
                r_rows <= '0;
                r_sum  <= '0;
            end else if (r4_v) begin
                r_sum <= sum_next[cel_pkg::SUM_W] ? cel_pkg::SUM_MAX
                                                  : sum_next[cel_pkg::SUM_W-1:0];
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        // Payload stages
        r1_x <= (i_prob == '0) ? cel_pkg::PROB_W'(1) : i_prob;

        r2_ge1 <= (r1_x >> cel_pkg::PROB_FRAC_BITS) != '0;
        r2_e   <= cel_pkg::FRAC_BITS5 - m1;
        r2_fr  <= cel_pkg::FRAC_W'(r1_x << (cel_pkg::LOG2_W'(cel_pkg::FRAC_W) - m1));

        r3_ge1  <= r2_ge1;
        r3_base <= cel_pkg::LOSS_W'(r2_e) * cel_pkg::LOSS_W'(cel_pkg::LN2_Q16);
        r3_tab  <= tab_lo;
        r3_prod <= diff * r2_fr[cel_pkg::STEP_W-1:0];

        r4_loss <= r3_ge1 ? '0 : r3_base - cel_pkg::LOSS_W'(ln1p);

        if (i_cmd.div_start) begin
            r_rows_snap <= r_rows;
        end
        if (i_cmd.load_out) begin
            r_mean     <= (quot[cel_pkg::DIVD_W-1:cel_pkg::MEAN_W] != '0)
                          ? cel_pkg::MEAN_MAX : quot[cel_pkg::MEAN_W-1:0];
            r_rows_out <= r_rows_snap;
        end
    end

    cel_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_rows),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign o_status.pipe_empty = ~(r1_v | r2_v | r3_v | r4_v);
    assign o_status.div_done   = div_done;
    assign o_status.out_free   = ~r_out_valid | ~i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_mean_loss = r_mean;
    assign o_rows_seen = r_rows_out;

endmodule

FILE: rtl/cel_ctrl.sv
// Controller: input flow, drain after a batch end, divide and result hand-off.
module cel_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_batch_end,
    input  cel_pkg::t_status   i_status,
    output cel_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            S_RUN: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_batch_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait until every queued loss has reached the sum
                if (i_status.pipe_empty) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_RUN);

endmodule

FILE: rtl/cross_entropy_loss_mean_unit.sv
// Top level of the batch mean cross-entropy loss unit.
// Throughput: one probability word per cycle within a batch.
// After a batch-end word the input stalls while the four-stage log pipeline drains into
// the sum, the one-bit-per-cycle divider runs and the result is loaded into the result
// register once the output side is free.
// Reset (synchronous, active low) clears the sum, row count, target flag and valid bits.
module cross_entropy_loss_mean_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // probability word stream
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cel_pkg::PROB_W-1:0]    i_prob,
    input  logic                          i_is_target,
    input  logic                          i_row_end,
    input  logic                          i_batch_end,
    // batch result word
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cel_pkg::MEAN_W-1:0]    o_mean_loss,
    output logic [cel_pkg::ROWS_W-1:0]    o_rows_seen
);

    cel_pkg::t_cmd    cmd;
    cel_pkg::t_status status;

    // Sequencing: accept words, drain, divide, hand the result to the output register.
    // A finished result may wait in the output register while the next batch streams in.
    cel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_batch_end (i_batch_end),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // Log pipeline, saturating sum, row counter, divider and result register.
    cel_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_prob      (i_prob),
        .i_is_target (i_is_target),
        .i_row_end   (i_row_end),
        .i_batch_end (i_batch_end),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_mean_loss (o_mean_loss),
        .o_rows_seen (o_rows_seen)
    );

endmodule

FILE: tb/cel_batch_checker.sv
// Batch loss checker: predicts every batch mean from the accepted words and compares results.
module cel_batch_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [cel_pkg::PROB_W-1:0]     i_prob,
    input  logic                           i_is_target,
    input  logic                           i_row_end,
    input  logic                           i_batch_end,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [cel_pkg::MEAN_W-1:0]     i_mean_loss,
    input  logic [cel_pkg::ROWS_W-1:0]     i_rows_seen,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [cel_pkg::MEAN_W-1:0] mean_loss;
        logic [cel_pkg::ROWS_W-1:0] rows_seen;
    } t_batch_result;

    // ln(1 + j/16) in Q16, entry j in bits [16*j +: 16]
    localparam logic [17*16-1:0] LN1P_Q16 = {
        16'd45426, 16'd43345, 16'd41196, 16'd38975, 16'd36675, 16'd34292,
        16'd31818, 16'd29248, 16'd26573, 16'd23783, 16'd20870, 16'd17821,
        16'd14624, 16'd11262, 16'd7719,  16'd3973,  16'd0
    };

    logic                          row_target_taken = 1'b0;
    logic [cel_pkg::SUM_W-1:0]     loss_acc = '0;
    logic [cel_pkg::ROWS_W-1:0]    rows_acc = '0;
    t_batch_result                 batch_means_due[$];
    int                            mismatches = 0;

    // -ln(p) in Q5.16; zero is lifted to one LSB, one and above cost nothing
    function automatic logic [cel_pkg::LOSS_W-1:0] minus_ln_prob(
        input logic [cel_pkg::PROB_W-1:0] p);
        int unsigned x, lead, rest, frac, seg, step, lo, hi, interp;
        x = (p == '0) ? 1 : p;
        if (x >= (32'd1 << cel_pkg::PROB_FRAC_BITS)) return '0;
        lead = 0;
        while (lead < 31 && (x >> (lead + 1)) != 0) lead++;
        rest = x - (32'd1 << lead);
        frac = (lead >= cel_pkg::FRAC_W) ? rest >> (lead - cel_pkg::FRAC_W)
                                         : rest << (cel_pkg::FRAC_W - lead);
        frac = frac & 32'hFFFF;
        seg  = frac >> 12;
        step = frac & 32'hFFF;
        lo   = LN1P_Q16[seg*16 +: 16];
        hi   = LN1P_Q16[(seg+1)*16 +: 16];
        interp = lo + (((hi - lo) * step + 2048) >> 12);
        return cel_pkg::LOSS_W'((cel_pkg::PROB_FRAC_BITS - lead) * cel_pkg::LN2_Q16 - interp);
    endfunction

    task automatic take_word();
        longint unsigned total, divisor, quotient;
        t_batch_result   res;
        if (i_is_target && !row_target_taken) begin
            total = longint'(loss_acc) + minus_ln_prob(i_prob);
            loss_acc = (total > cel_pkg::SUM_MAX) ? cel_pkg::SUM_MAX : cel_pkg::SUM_W'(total);
            row_target_taken = 1'b1;
        end
        if (i_row_end || i_batch_end) begin
            row_target_taken = 1'b0;
            if (rows_acc < cel_pkg::ROW_CAP) rows_acc++;
        end
        if (i_batch_end) begin
            divisor  = (rows_acc == '0) ? 1 : rows_acc;
            quotient = (longint'(loss_acc) + (divisor >> 1)) / divisor;
            res.mean_loss = (quotient > cel_pkg::MEAN_MAX) ? cel_pkg::MEAN_MAX
                                                           : cel_pkg::MEAN_W'(quotient);
            res.rows_seen = rows_acc;
            batch_means_due.push_back(res);
            loss_acc = '0;
            rows_acc = '0;
        end
    endtask

    task automatic check_result();
        t_batch_result want;
        if (batch_means_due.size() == 0) begin
            $error("result word with no batch pending: mean_loss %0d rows_seen %0d",
                   i_mean_loss, i_rows_seen);
            mismatches++;
        end else begin
            want = batch_means_due.pop_front();
            if (i_mean_loss !== want.mean_loss) begin
                $error("mean_loss: expected %0d, actual %0d", want.mean_loss, i_mean_loss);
                mismatches++;
            end
            if (i_rows_seen !== want.rows_seen) begin
                $error("rows_seen: expected %0d, actual %0d", want.rows_seen, i_rows_seen);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_target_taken = 1'b0;
            loss_acc = '0;
            rows_acc = '0;
            batch_means_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) take_word();
            if (i_out_valid && !i_out_stall) check_result();
        end
        o_fail_count <= mismatches;
        o_pending    <= batch_means_due.size();
    end

endmodule

FILE: tb/cross_entropy_loss_mean_unit_test.sv
// Top of the loss unit testbench: clock, reset, word stimulus, output stalls and verdict.
module cross_entropy_loss_mean_unit_test;

    localparam logic [cel_pkg::PROB_W-1:0] PROB_ONE =
        cel_pkg::PROB_W'(1 << cel_pkg::PROB_FRAC_BITS);

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [cel_pkg::PROB_W-1:0]    prob = '0;
    logic                          is_target = 1'b0;
    logic                          row_end = 1'b0;
    logic                          batch_end = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [cel_pkg::MEAN_W-1:0]    mean_loss;
    logic [cel_pkg::ROWS_W-1:0]    rows_seen;

    // Idling switch for both sides; cleared for the closing stretch of the run
    logic gaps_on = 1'b1;
    int   stall_left = 0;
    int   words_sent = 0;
    int   fail_count;
    int   pending;

    always #5 clk = ~clk;

    cross_entropy_loss_mean_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_prob      (prob),
        .i_is_target (is_target),
        .i_row_end   (row_end),
        .i_batch_end (batch_end),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_mean_loss (mean_loss),
        .o_rows_seen (rows_seen)
    );

    cel_batch_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_prob       (prob),
        .i_is_target  (is_target),
        .i_row_end    (row_end),
        .i_batch_end  (batch_end),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_mean_loss  (mean_loss),
        .i_rows_seen  (rows_seen),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side in random bursts while idling is on.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Offer one word and hold it until the block takes it. An optional gap of idle
    // cycles goes in front; without one, valid stays high so that back-to-back words
    // see no bubble.
    task automatic send_word(input logic [cel_pkg::PROB_W-1:0] p, input logic tgt,
                             input logic re, input logic be);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        prob      <= p;
        is_target <= tgt;
        row_end   <= re;
        batch_end <= be;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Mix of probabilities: clamp to one LSB, one, tiny values with large
    // losses, exact powers of two, values just under one, and anything in range.
    function automatic logic [cel_pkg::PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PROB_ONE;
            2:       return cel_pkg::PROB_W'($urandom_range(0, 255));
            3:       return cel_pkg::PROB_W'(1 << $urandom_range(0, cel_pkg::PROB_FRAC_BITS));
            4:       return cel_pkg::PROB_W'($urandom_range(PROB_ONE - 536, PROB_ONE));
            default: return cel_pkg::PROB_W'($urandom_range(0, PROB_ONE));
        endcase
    endfunction

    // One batch of random shape. Most rows carry a single target at a random
    // class; some have none, some a second one, and a few are noise with
    // random target flags. A quarter of batches end without a row-end mark.
    task automatic run_random_batch();
        int   rows, classes, hit, extra, r, c;
        logic noisy, tgt, re, be, cut_row_end;
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        cut_row_end = ($urandom_range(0, 3) == 0);
        for (r = 0; r < rows; r++) begin
            classes = $urandom_range(1, 10);
            hit   = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, classes - 1);
            extra = ($urandom_range(0, 5) == 0) ? $urandom_range(0, classes - 1) : -1;
            noisy = ($urandom_range(0, 11) == 0);
            for (c = 0; c < classes; c++) begin
                tgt = noisy ? 1'($urandom_range(0, 1)) : (c == hit || c == extra);
                be  = (r == rows - 1) && (c == classes - 1);
                re  = (c == classes - 1) && !(be && cut_row_end);
                send_word(pick_prob(), tgt, re, be);
            end
        end
    endtask

    initial begin
        int waited;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Batch of six rows covering the corners of a single row.
        send_word('0, 1'b1, 1'b1, 1'b0);            // zero probability, clamp to one LSB
        send_word(PROB_ONE, 1'b1, 1'b1, 1'b0);      // probability of one costs nothing
        send_word(cel_pkg::PROB_W'(1), 1'b1, 1'b0, 1'b0);     // smallest non-zero value
        send_word(cel_pkg::PROB_W'(32768), 1'b1, 1'b1, 1'b0); // second target in the row
        send_word(cel_pkg::PROB_W'(12345), 1'b0, 1'b0, 1'b0);
        send_word(PROB_ONE - cel_pkg::PROB_W'(1), 1'b1, 1'b1, 1'b0); // just under one
        send_word(cel_pkg::PROB_W'(100), 1'b0, 1'b0, 1'b0); // row without a target counts
        send_word(cel_pkg::PROB_W'(200), 1'b0, 1'b1, 1'b0);
        send_word(cel_pkg::PROB_W'(40000), 1'b1, 1'b0, 1'b1); // batch end closes the row

        // Single-word batches, with and without a target.
        send_word(cel_pkg::PROB_W'(2), 1'b1, 1'b1, 1'b1);
        send_word(cel_pkg::PROB_W'(54321), 1'b0, 1'b1, 1'b1);
        send_word(PROB_ONE, 1'b1, 1'b0, 1'b1);

        // Powers of two and a target on a batch-end word after a targetless word in its row.
        send_word(cel_pkg::PROB_W'(256), 1'b1, 1'b1, 1'b0);
        send_word(cel_pkg::PROB_W'(4096), 1'b1, 1'b1, 1'b0);
        send_word(cel_pkg::PROB_W'(49152), 1'b1, 1'b0, 1'b0);
        send_word(cel_pkg::PROB_W'(3), 1'b0, 1'b1, 1'b0);
        send_word(cel_pkg::PROB_W'(65535), 1'b0, 1'b0, 1'b0);
        send_word(cel_pkg::PROB_W'(1), 1'b1, 1'b1, 1'b1);

        // Random batches; drop all idling for the last stretch.
        while (words_sent < 1000) begin
            if (words_sent >= 800) gaps_on <= 1'b0;
            run_random_batch();
        end
        in_valid <= 1'b0;

        // Let the checker register the last batch, then drain the results.
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("cross_entropy_loss_mean_unit_test: PASS");
        end else begin
            $display("cross_entropy_loss_mean_unit_test: FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #3000000;
        $display("cross_entropy_loss_mean_unit_test: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cel_pkg.sv
rtl/cel_div.sv
rtl/cel_dp.sv
rtl/cel_ctrl.sv
rtl/cross_entropy_loss_mean_unit.sv
tb/cel_batch_checker.sv
tb/cross_entropy_loss_mean_unit_test.sv
